// ===== rtl/lpg_pkg.sv =====
// shared constants, payload types and control structs of the line pixel generator
package lpg_pkg;

   // coordinate and fixed-point sizes
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;

   // endpoint differences carry one extra bit
   localparam int DIFF_W    = COORD_BITS + 1;
   // running minor accumulator: sign, integer headroom, fraction
   localparam int ACC_W     = COORD_BITS + FRAC_BITS + 2;
   // rounded minor before saturation
   localparam int MINOR_W   = ACC_W - FRAC_BITS;
   // quotient has one extra fraction bit for rounding
   localparam int QUO_W     = FRAC_BITS + 2;
   localparam int SLOPE_W   = FRAC_BITS + 2;
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN = -(1 << (COORD_BITS - 1));

   // command codes of the input word
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic      cmd;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic fix_slope;
      logic emit;
   } lpg_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic dmaj_zero;
      logic at_end;
   } lpg_status_type;

endpackage

// ===== rtl/lpg_datapath.sv =====
// datapath: endpoint decode, slope divider, minor accumulator and pixel register
module lpg_datapath (
   input  logic                   clock,
   input  lpg_pkg::req_type       req_data,
   input  lpg_pkg::lpg_cmd_type   cmd,
   output lpg_pkg::lpg_status_type status,
   output lpg_pkg::rsp_type       rsp_data
);

   localparam logic signed [lpg_pkg::MINOR_W-1:0] MINOR_HI =
      lpg_pkg::MINOR_W'(lpg_pkg::COORD_MAX);
   localparam logic signed [lpg_pkg::MINOR_W-1:0] MINOR_LO =
      lpg_pkg::MINOR_W'(lpg_pkg::COORD_MIN);
   localparam logic [lpg_pkg::ACC_W-1:0] ACC_HALF =
      lpg_pkg::ACC_W'(1) << (lpg_pkg::FRAC_BITS - 1);

   // line registers
   logic                                 steep_ff, steep_in;
   logic                                 step_negative_ff, step_negative_in;
   logic                                 slope_neg_ff, slope_neg_in;
   lpg_pkg::coord_type                   major_pos_ff, major_pos_in;
   lpg_pkg::coord_type                   major_end_ff, major_end_in;
   lpg_pkg::coord_type                   end_x_ff, end_x_in;
   lpg_pkg::coord_type                   end_y_ff, end_y_in;
   logic signed [lpg_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic signed [lpg_pkg::SLOPE_W-1:0]   slope_ff, slope_in;
   // divider registers
   logic [lpg_pkg::COORD_BITS-1:0]       den_ff, den_in;
   logic [lpg_pkg::COORD_BITS:0]         rem_ff, rem_in;
   logic [lpg_pkg::QUO_W-1:0]            quo_ff, quo_in;
   // result word
   lpg_pkg::rsp_type                     rsp_ff, rsp_in;

   // endpoint decode
   logic signed [lpg_pkg::DIFF_W-1:0] dx, dy;
   logic [lpg_pkg::COORD_BITS-1:0]    adx, ady, amaj, amin;
   logic                              start_steep, dmaj_neg, dmin_neg;
   lpg_pkg::coord_type                maj0, min0, maj1;

   always_comb begin
      dx = lpg_pkg::DIFF_W'(req_data.x_end) - lpg_pkg::DIFF_W'(req_data.x_start);
      dy = lpg_pkg::DIFF_W'(req_data.y_end) - lpg_pkg::DIFF_W'(req_data.y_start);
      adx = dx[lpg_pkg::DIFF_W-1] ? lpg_pkg::COORD_BITS'(-dx) : lpg_pkg::COORD_BITS'(dx);
      ady = dy[lpg_pkg::DIFF_W-1] ? lpg_pkg::COORD_BITS'(-dy) : lpg_pkg::COORD_BITS'(dy);
      start_steep = !(ady < adx);
      if (start_steep) begin
         amaj     = ady;
         amin     = adx;
         dmaj_neg = dy[lpg_pkg::DIFF_W-1];
         dmin_neg = dx[lpg_pkg::DIFF_W-1];
         maj0     = req_data.y_start;
         min0     = req_data.x_start;
         maj1     = req_data.y_end;
      end else begin
         amaj     = adx;
         amin     = ady;
         dmaj_neg = dx[lpg_pkg::DIFF_W-1];
         dmin_neg = dy[lpg_pkg::DIFF_W-1];
         maj0     = req_data.x_start;
         min0     = req_data.y_start;
         maj1     = req_data.x_end;
      end
   end

   // one restoring division step
   logic                             rem_ge;
   logic [lpg_pkg::COORD_BITS:0]     rem_diff;

   always_comb begin
      rem_ge   = rem_ff >= {1'b0, den_ff};
      rem_diff = rem_ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;
   end

   // quotient rounded half away from zero, then signed
   logic [lpg_pkg::QUO_W-1:0]        quo_plus;
   logic [lpg_pkg::SLOPE_W-1:0]      slope_mag;

   always_comb begin
      quo_plus  = quo_ff + lpg_pkg::QUO_W'(1);
      slope_mag = {1'b0, quo_plus[lpg_pkg::QUO_W-1:1]};
   end

   // minor coordinate: round the accumulator and saturate
   logic [lpg_pkg::ACC_W-1:0]         acc_bias;
   logic signed [lpg_pkg::MINOR_W-1:0] minor_wide;
   lpg_pkg::coord_type                minor;

   always_comb begin
      acc_bias   = acc_ff + ACC_HALF - lpg_pkg::ACC_W'(acc_ff[lpg_pkg::ACC_W-1]);
      minor_wide = acc_bias[lpg_pkg::ACC_W-1:lpg_pkg::FRAC_BITS];
      if (minor_wide > MINOR_HI) begin
         minor = lpg_pkg::COORD_BITS'(MINOR_HI);
      end else if (minor_wide < MINOR_LO) begin
         minor = lpg_pkg::COORD_BITS'(MINOR_LO);
      end else begin
         minor = lpg_pkg::COORD_BITS'(minor_wide);
      end
   end

   assign status.dmaj_zero = (amaj == '0);
   assign status.at_end    = (major_pos_ff == major_end_ff);

   // next values
   always_comb begin
      steep_in         = steep_ff;
      step_negative_in = step_negative_ff;
      slope_neg_in     = slope_neg_ff;
      major_pos_in     = major_pos_ff;
      major_end_in     = major_end_ff;
      end_x_in         = end_x_ff;
      end_y_in         = end_y_ff;
      acc_in           = acc_ff;
      slope_in         = slope_ff;
      den_in           = den_ff;
      rem_in           = rem_ff;
      quo_in           = quo_ff;
      rsp_in           = rsp_ff;

      if (cmd.load) begin
         steep_in         = start_steep;
         step_negative_in = dmaj_neg;
         slope_neg_in     = dmaj_neg ^ dmin_neg;
         major_pos_in     = maj0;
         major_end_in     = maj1;
         end_x_in         = req_data.x_end;
         end_y_in         = req_data.y_end;
         // the accumulator starts at the exact minor start
         acc_in           = {{(lpg_pkg::ACC_W - lpg_pkg::COORD_BITS - lpg_pkg::FRAC_BITS)
                               {min0[lpg_pkg::COORD_BITS-1]}},
                             min0, {lpg_pkg::FRAC_BITS{1'b0}}};
         slope_in         = '0;
         den_in           = amaj;
         rem_in           = {1'b0, amin};
         quo_in           = '0;
      end

      if (cmd.div_step) begin
         rem_in = {rem_diff[lpg_pkg::COORD_BITS-1:0], 1'b0};
         quo_in = {quo_ff[lpg_pkg::QUO_W-2:0], rem_ge};
      end

      if (cmd.fix_slope) begin
         slope_in = slope_neg_ff ? -slope_mag : slope_mag;
      end

      if (cmd.emit) begin
         if (status.at_end) begin
            rsp_in.pixel_x = end_x_ff;
            rsp_in.pixel_y = end_y_ff;
            rsp_in.last    = 1'b1;
         end else begin
            if (steep_ff) begin
               rsp_in.pixel_x = minor;
               rsp_in.pixel_y = major_pos_ff;
            end else begin
               rsp_in.pixel_x = major_pos_ff;
               rsp_in.pixel_y = minor;
            end
            rsp_in.last = 1'b0;
            if (step_negative_ff) begin
               major_pos_in = major_pos_ff - lpg_pkg::COORD_BITS'(1);
               acc_in       = acc_ff - lpg_pkg::ACC_W'(slope_ff);
            end else begin
               major_pos_in = major_pos_ff + lpg_pkg::COORD_BITS'(1);
               acc_in       = acc_ff + lpg_pkg::ACC_W'(slope_ff);
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      steep_ff         <= steep_in;
      step_negative_ff <= step_negative_in;
      slope_neg_ff     <= slope_neg_in;
      major_pos_ff     <= major_pos_in;
      major_end_ff     <= major_end_in;
      end_x_ff         <= end_x_in;
      end_y_ff         <= end_y_in;
      acc_ff           <= acc_in;
      slope_ff         <= slope_in;
      den_ff           <= den_in;
      rem_ff           <= rem_in;
      quo_ff           <= quo_in;
      rsp_ff           <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/lpg_ctrl.sv =====
// controller: line state machine, divider step count and result word valid
module lpg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_cmd,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  lpg_pkg::lpg_status_type status,
   output lpg_pkg::lpg_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_FIX  = 4'b0100,
      ST_RUN  = 4'b1000
   } lpg_state_type;

   lpg_state_type              state_ff, state_in;
   logic [lpg_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       req_take;

   // words are taken while no line is being set up and the result slot frees
   assign req_ready = ((state_ff == ST_IDLE) || (state_ff == ST_RUN)) &&
                      (!rsp_valid_ff || rsp_ready);
   assign req_take  = req_valid && req_ready;

   // commands to the datapath
   always_comb begin
      cmd.load      = req_take && (req_cmd == lpg_pkg::CMD_START);
      cmd.emit      = req_take && (req_cmd == lpg_pkg::CMD_STEP) && (state_ff == ST_RUN);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.fix_slope = (state_ff == ST_FIX);
   end

   // state sequencing
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE, ST_RUN: begin
            if (cmd.load) begin
               cnt_in   = lpg_pkg::CNT_W'(lpg_pkg::DIV_STEPS - 1);
               state_in = status.dmaj_zero ? ST_RUN : ST_DIV;
            end else if (cmd.emit && status.at_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_FIX;
            end else begin
               cnt_in = cnt_ff - lpg_pkg::CNT_W'(1);
            end
         end
         ST_FIX: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result word valid
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // a pixel is never written over one still waiting
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("pixel emitted over a pending word");

   // a non-degenerate start goes to the divider
   a_start_divides: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !status.dmaj_zero) |=> (state_ff == ST_DIV))
      else $error("start did not enter the divider");

   // the slope fix follows the last division step
   a_fix_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |-> ($past(state_ff) == ST_DIV && $past(cnt_ff) == '0))
      else $error("slope fix out of sequence");

   // the end pixel closes the line
   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.at_end && !cmd.load) |=> (state_ff == ST_IDLE))
      else $error("line not closed after its end point");
`endif

endmodule

// ===== rtl/line_pixel_generator.sv =====
// Line pixel generator top level: controller and datapath.
// Start word: accepted, then slope division in ST_DIV (one quotient bit per
// cycle) and slope rounding in ST_FIX; a line with equal endpoints skips
// both and takes steps from the next cycle. Step word: one pixel per cycle
// while the result slot is free, from the running minor accumulator, result
// registered the cycle after acceptance. Synchronous reset idles the block.
module line_pixel_generator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lpg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lpg_pkg::rsp_type rsp_data
);

   lpg_pkg::lpg_cmd_type    cmd;
   lpg_pkg::lpg_status_type status;

   // sequencing
   lpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and line state
   lpg_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
